### src/bvm_pkg.sv
package bvm_pkg;

  // Averaging depth
  localparam int SAMPLES = 16;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int MV_W     = 15;
  localparam int PCT_W    = 7;
  localparam int CELLS_W  = 3;
  localparam int SEL_W    = 3;
  localparam int OFFSET_W = 12;
  localparam int SUM_W    = 16;
  localparam int COUNT_W  = 7;

  // Scaling: full scale of the divided input against the 5 V reference
  localparam int FULL_SCALE_MV = 28500;
  localparam int SCALE_W       = 15;
  localparam int PROD_W        = SUM_W + SCALE_W;
  localparam int AVG_DIVISOR   = SAMPLES * 1024;
  localparam int DIVD_W        = PROD_W;
  localparam int DIVS_W        = 17;
  localparam int AVG_Q_W       = PROD_W - 10;

  localparam int MV_MAX        = (1 << MV_W) - 1;
  localparam int FLAT_FLOOR_MV = 1600;
  localparam int MV_PER_TENTH  = 100;
  localparam int TENTH_W       = 9;
  localparam int PCT_SLOPE     = 99;
  localparam int PCT_MAX       = 100;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CELL_SELECT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_TWO     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TWO     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_THREE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_THREE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_FOUR    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_FOUR    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CAL_OFFSET  = 3'd7;

  localparam logic CMD_MONITOR = 1'b0;
  localparam logic CMD_DETECT  = 1'b1;

  localparam logic [CELLS_W-1:0] CELLS_AUTO  = 3'd0;
  localparam logic [CELLS_W-1:0] CELLS_TWO   = 3'd2;
  localparam logic [CELLS_W-1:0] CELLS_THREE = 3'd3;
  localparam logic [CELLS_W-1:0] CELLS_FOUR  = 3'd4;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [MV_W-1:0]    voltage_mv;
    logic [PCT_W-1:0]   percent;
    logic               flat;
    logic [CELLS_W-1:0] cell_count;
    logic               from_detect;
  } result_t;

  typedef struct packed {
    logic [SEL_W-1:0]           cell_select;
    logic [MV_W-1:0]            min_two_cell_mv;
    logic [MV_W-1:0]            max_two_cell_mv;
    logic [MV_W-1:0]            min_three_cell_mv;
    logic [MV_W-1:0]            max_three_cell_mv;
    logic [MV_W-1:0]            min_four_cell_mv;
    logic [MV_W-1:0]            max_four_cell_mv;
    logic signed [OFFSET_W-1:0] cal_offset_mv;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_AVG,
    ST_DIV_X,
    ST_DIV_LO,
    ST_DIV_HI,
    ST_DIV_P,
    ST_OUT
  } bvm_state_t;

  function automatic logic [CELLS_W-1:0] cells_in_effect(
    input logic [SEL_W-1:0]   sel,
    input logic [CELLS_W-1:0] detected
  );
    logic [CELLS_W-1:0] c;
    if (sel == CELLS_AUTO) begin
      c = detected;
    end else if (sel == CELLS_THREE || sel == CELLS_FOUR) begin
      c = sel;
    end else begin
      c = CELLS_TWO;
    end
    return c;
  endfunction

  // Add the signed offset to the scaled average, clamp to 0..MV_MAX
  function automatic logic [MV_W-1:0] clamp_mv(
    input logic [AVG_Q_W-1:0]        q,
    input logic signed [OFFSET_W-1:0] off
  );
    logic signed [AVG_Q_W+1:0] r;
    logic [MV_W-1:0]           v;
    r = $signed({2'b00, q}) + $signed({{(AVG_Q_W+2-OFFSET_W){off[OFFSET_W-1]}}, off});
    if (r[AVG_Q_W+1]) begin
      v = '0;
    end else if (|r[AVG_Q_W:MV_W]) begin
      v = MV_W'(MV_MAX);
    end else begin
      v = r[MV_W-1:0];
    end
    return v;
  endfunction

endpackage

### src/bvm_regs.sv
module bvm_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bvm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bvm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bvm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output bvm_pkg::cfg_t                   cfg
);
  import bvm_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_select       <= '0;
      cfg.min_two_cell_mv   <= MV_W'(6400);
      cfg.max_two_cell_mv   <= MV_W'(8400);
      cfg.min_three_cell_mv <= MV_W'(9600);
      cfg.max_three_cell_mv <= MV_W'(12600);
      cfg.min_four_cell_mv  <= MV_W'(12800);
      cfg.max_four_cell_mv  <= MV_W'(16800);
      cfg.cal_offset_mv     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_CELL_SELECT: cfg.cell_select       <= pwdata[SEL_W-1:0];
        REG_MIN_TWO:     cfg.min_two_cell_mv   <= pwdata[MV_W-1:0];
        REG_MAX_TWO:     cfg.max_two_cell_mv   <= pwdata[MV_W-1:0];
        REG_MIN_THREE:   cfg.min_three_cell_mv <= pwdata[MV_W-1:0];
        REG_MAX_THREE:   cfg.max_three_cell_mv <= pwdata[MV_W-1:0];
        REG_MIN_FOUR:    cfg.min_four_cell_mv  <= pwdata[MV_W-1:0];
        REG_MAX_FOUR:    cfg.max_four_cell_mv  <= pwdata[MV_W-1:0];
        REG_CAL_OFFSET:  cfg.cal_offset_mv     <= $signed(pwdata[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CELL_SELECT: prdata = APB_DATA_W'(cfg.cell_select);
      REG_MIN_TWO:     prdata = APB_DATA_W'(cfg.min_two_cell_mv);
      REG_MAX_TWO:     prdata = APB_DATA_W'(cfg.max_two_cell_mv);
      REG_MIN_THREE:   prdata = APB_DATA_W'(cfg.min_three_cell_mv);
      REG_MAX_THREE:   prdata = APB_DATA_W'(cfg.max_three_cell_mv);
      REG_MIN_FOUR:    prdata = APB_DATA_W'(cfg.min_four_cell_mv);
      REG_MAX_FOUR:    prdata = APB_DATA_W'(cfg.max_four_cell_mv);
      REG_CAL_OFFSET:  prdata = APB_DATA_W'(unsigned'(cfg.cal_offset_mv));
      default:         prdata = '0;
    endcase
  end

endmodule

### src/bvm_mul.sv
module bvm_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bvm_pkg::SUM_W-1:0]    sum,
  output logic                         done,
  output logic [bvm_pkg::PROD_W-1:0]   product
);
  import bvm_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(SUM_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [SUM_W-1:0]  mplier;
  logic [PROD_W-1:0] mcand;
  logic [PROD_W-1:0] acc;

  assign product = acc;

  // One multiplier bit per cycle, LSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mplier <= sum;
      mcand  <= PROD_W'(FULL_SCALE_MV);
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mplier <= mplier >> 1;
      mcand  <= mcand << 1;
    end
  end

endmodule

### src/bvm_div.sv
module bvm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bvm_pkg::DIVD_W-1:0]   dividend,
  input  logic [bvm_pkg::DIVS_W-1:0]   divisor,
  output logic                         done,
  output logic [bvm_pkg::DIVD_W-1:0]   quotient
);
  import bvm_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVD_W - 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] work;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W+1:0] diff;
  logic              qbit;

  assign quotient = work;

  // Restoring division, one quotient bit per cycle, MSB first
  always_comb begin
    trial = {rem, work[DIVD_W-1]};
    diff  = {1'b0, trial} - {2'b00, dvs};
    qbit  = ~diff[DIVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= qbit ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
      work <= {work[DIVD_W-2:0], qbit};
    end
  end

endmodule

### src/battery_voltage_monitor_core.sv
// Averaging battery voltage monitor. Each item is either a monitor sample
// (cmd 0) or a detection sample (cmd 1). Monitor samples are summed until
// SAMPLES have been taken; the next monitor item is dropped and instead
// triggers a result: the average scaled to millivolts plus the calibration
// offset (clamped to 0..32767), a flat flag and a 0..100 charge percentage
// against the min/max limits of the cell count in effect. Detection items
// are summed separately; the item that completes SAMPLES of them gives a
// result that also updates the detected cell count (2, 3 or 4).
// An item that only accumulates is taken without leaving the idle state,
// so the block stays ready for the next one. An item that triggers a result
// occupies the block through a bit-serial multiply by the full-scale
// constant followed by one (detection) or four or five (monitor) passes
// through a shared radix-2 restoring divider of 31 iterations each; the
// percent division is skipped when both limits fall in the same tenth.
// The result sits in an output register, so accumulating items are taken
// while it waits to be collected. Configuration is through an APB-style
// port, register i at byte address 4*i, pready always high.
module battery_voltage_monitor_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  bvm_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output bvm_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bvm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bvm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [bvm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import bvm_pkg::*;

  localparam logic [COUNT_W-1:0] SAMPLES_C = COUNT_W'(SAMPLES);

  cfg_t cfg;

  bvm_state_t state, state_next;

  // Accumulators
  logic [SUM_W-1:0]   monitor_sum;
  logic [COUNT_W-1:0] monitor_count;
  logic [SUM_W-1:0]   detect_sum;
  logic [COUNT_W-1:0] detect_count;
  logic [CELLS_W-1:0] detected_cells;

  // Per-result working registers
  logic               is_detect;
  logic [MV_W-1:0]    mv;
  logic [TENTH_W-1:0] tx;
  logic [TENTH_W-1:0] tlo;
  logic [TENTH_W-1:0] thi;
  logic [PCT_W-1:0]   pct;
  logic               div_go, div_go_next;

  logic               accept;
  logic               fire;
  logic [SUM_W-1:0]   dsum_add;
  logic [COUNT_W-1:0] dcount_add;
  logic [SUM_W-1:0]   mul_sum;
  logic               mul_done;
  logic [PROD_W-1:0]  product;
  logic               div_done;
  logic [DIVD_W-1:0]  div_q;
  logic [DIVD_W-1:0]  div_dividend;
  logic [DIVS_W-1:0]  div_divisor;
  logic               out_load;

  logic [CELLS_W-1:0] cells_eff;
  logic [MV_W-1:0]    lo_mv;
  logic [MV_W-1:0]    hi_mv;
  logic [MV_W-1:0]    mv_new;
  logic [TENTH_W-1:0] q_tenth;

  logic signed [TENTH_W:0]   diff_s;
  logic signed [TENTH_W:0]   den_s;
  logic signed [TENTH_W+7:0] num_s;
  logic [TENTH_W+7:0]        num_mag;
  logic [TENTH_W:0]          den_mag;
  logic                      p_neg;
  logic [MV_W:0]             p_q;

  bvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bvm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (fire),
    .sum     (mul_sum),
    .done    (mul_done),
    .product (product)
  );

  bvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // Input decode: does this item accumulate or trigger a result?
  always_comb begin
    accept     = item_valid & item_ready;
    dsum_add   = detect_sum + SUM_W'(item.sample);
    dcount_add = detect_count + 1'b1;
    if (item.cmd == CMD_DETECT) begin
      fire    = accept && (dcount_add >= SAMPLES_C);
      mul_sum = dsum_add;
    end else begin
      fire    = accept && (monitor_count >= SAMPLES_C);
      mul_sum = monitor_sum;
    end
  end

  // Limits of the cell count in effect
  always_comb begin
    cells_eff = cells_in_effect(cfg.cell_select, detected_cells);
    case (cells_eff)
      CELLS_FOUR: begin
        lo_mv = cfg.min_four_cell_mv;
        hi_mv = cfg.max_four_cell_mv;
      end
      CELLS_THREE: begin
        lo_mv = cfg.min_three_cell_mv;
        hi_mv = cfg.max_three_cell_mv;
      end
      default: begin
        lo_mv = cfg.min_two_cell_mv;
        hi_mv = cfg.max_two_cell_mv;
      end
    endcase
  end

  // Percent numerator and denominator in tenths of a volt, sign split off
  always_comb begin
    mv_new  = clamp_mv(div_q[AVG_Q_W-1:0], cfg.cal_offset_mv);
    q_tenth = div_q[TENTH_W-1:0];
    diff_s  = $signed({1'b0, tx}) - $signed({1'b0, tlo});
    den_s   = $signed({1'b0, thi}) - $signed({1'b0, tlo});
    num_s   = (TENTH_W+8)'(diff_s) * $signed((TENTH_W+8)'(PCT_SLOPE));
    num_mag = num_s[TENTH_W+7] ? (TENTH_W+8)'(-num_s) : num_s;
    den_mag = den_s[TENTH_W] ? (TENTH_W+1)'(-den_s) : den_s;
    p_neg   = num_s[TENTH_W+7] ^ den_s[TENTH_W];
    p_q     = div_q[MV_W:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (fire) state_next = ST_MUL;
      ST_MUL:     if (mul_done) state_next = ST_DIV_AVG;
      ST_DIV_AVG: if (div_done) state_next = is_detect ? ST_OUT : ST_DIV_X;
      ST_DIV_X:   if (div_done) state_next = ST_DIV_LO;
      ST_DIV_LO:  if (div_done) state_next = ST_DIV_HI;
      ST_DIV_HI: begin
        if (div_done) begin
          state_next = (q_tenth == tlo) ? ST_OUT : ST_DIV_P;
        end
      end
      ST_DIV_P:   if (div_done) state_next = ST_OUT;
      ST_OUT:     if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Control outputs and divider operand select
  always_comb begin
    item_ready  = (state == ST_IDLE);
    out_load    = (state == ST_OUT) && (!result_valid || result_ready);
    div_go_next = (state_next != state) &&
                  (state_next inside {ST_DIV_AVG, ST_DIV_X, ST_DIV_LO, ST_DIV_HI, ST_DIV_P});
    case (state)
      ST_DIV_X: begin
        div_dividend = DIVD_W'(mv);
        div_divisor  = DIVS_W'(MV_PER_TENTH);
      end
      ST_DIV_LO: begin
        div_dividend = DIVD_W'(lo_mv);
        div_divisor  = DIVS_W'(MV_PER_TENTH);
      end
      ST_DIV_HI: begin
        div_dividend = DIVD_W'(hi_mv);
        div_divisor  = DIVS_W'(MV_PER_TENTH);
      end
      ST_DIV_P: begin
        div_dividend = DIVD_W'(num_mag);
        div_divisor  = DIVS_W'(den_mag);
      end
      default: begin
        div_dividend = product;
        div_divisor  = DIVS_W'(AVG_DIVISOR);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      div_go <= 1'b0;
    end else begin
      state  <= state_next;
      div_go <= div_go_next;
    end
  end

  // Accumulators and detected cell count
  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_sum    <= '0;
      monitor_count  <= '0;
      detect_sum     <= '0;
      detect_count   <= '0;
      detected_cells <= CELLS_TWO;
      is_detect      <= 1'b0;
    end else begin
      if (accept) begin
        if (item.cmd == CMD_DETECT) begin
          // Sample counts toward the average; clear once the set is complete
          if (fire) begin
            detect_sum   <= '0;
            detect_count <= '0;
          end else begin
            detect_sum   <= dsum_add;
            detect_count <= dcount_add;
          end
        end else if (fire) begin
          // Drop this sample; it only triggers the result
          monitor_sum   <= '0;
          monitor_count <= '0;
        end else begin
          monitor_sum   <= monitor_sum + SUM_W'(item.sample);
          monitor_count <= monitor_count + 1'b1;
        end
        if (fire) begin
          is_detect <= (item.cmd == CMD_DETECT);
        end
      end
      if (state == ST_DIV_AVG && div_done && is_detect) begin
        if (mv_new < cfg.min_four_cell_mv) begin
          detected_cells <= (mv_new < cfg.min_three_cell_mv) ? CELLS_TWO : CELLS_THREE;
        end else begin
          detected_cells <= CELLS_FOUR;
        end
      end
    end
  end

  // Working values, written as each division completes
  always_ff @(posedge clk) begin
    if (div_done) begin
      case (state)
        ST_DIV_AVG: mv  <= mv_new;
        ST_DIV_X:   tx  <= q_tenth;
        ST_DIV_LO:  tlo <= q_tenth;
        ST_DIV_HI: begin
          thi <= q_tenth;
          // Equal limits: full or empty, nothing in between
          pct <= (tx >= q_tenth) ? PCT_W'(PCT_MAX) : '0;
        end
        ST_DIV_P: begin
          // Quotient truncates toward zero; add one and clamp to 0..100
          if (p_neg) begin
            pct <= (p_q == '0) ? PCT_W'(1) : '0;
          end else if (p_q >= (MV_W+1)'(PCT_MAX - 1)) begin
            pct <= PCT_W'(PCT_MAX);
          end else begin
            pct <= PCT_W'(p_q) + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register; hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.voltage_mv  <= mv;
      result.percent     <= is_detect ? '0 : pct;
      result.flat        <= !is_detect && (mv < lo_mv) &&
                            (mv > MV_W'(FLAT_FLOOR_MV));
      result.cell_count  <= cells_eff;
      result.from_detect <= is_detect;
    end
  end

endmodule

### src/bvm_checker.sv
module bvm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           result_valid,
  input logic                           result_ready,
  input bvm_pkg::result_t               result
);
  import bvm_pkg::*;

  // A result that is not taken stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or vanished while stalled");

  // Detection results carry no percent and no flat flag
  a_detect_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.from_detect |-> result.percent == '0 && !result.flat)
    else $error("detection result with percent or flat set");

  // Percent stays within 0..100 and cell count within 2..4
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.percent <= PCT_W'(PCT_MAX) &&
                     result.cell_count >= CELLS_TWO && result.cell_count <= CELLS_FOUR)
    else $error("percent or cell count out of range");

  // Flat is only reported above the flat floor
  a_flat_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.flat |-> result.voltage_mv > MV_W'(FLAT_FLOOR_MV))
    else $error("flat reported at or below the floor");

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind battery_voltage_monitor_core bvm_checker u_bvm_checker (.*);
